// ===== design/spr_pkg.sv =====
`timescale 1ns / 1ps
package spr_pkg;

  localparam int MAX_ENTRIES_DEF = 256;

  localparam int ENTRY_W    = 9;
  localparam int ACT_W      = 3;
  localparam int POS_W      = 8;
  localparam int POSK_W     = 9;
  localparam int LEN_W      = 9;
  localparam int MODEL_W    = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE     = 3'd0,
    ACT_READ      = 3'd1,
    ACT_REVERSE   = 3'd2,
    ACT_TRANSPOSE = 3'd3,
    ACT_FIND      = 3'd4,
    ACT_BREAK     = 3'd5,
    ACT_STRIP     = 3'd6,
    ACT_SORTED    = 3'd7
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_NOT_ALLOWED = 2'd1,
    ST_RANGE       = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGNED = 2'd0,
    CFG_MODEL  = 2'd1,
    CFG_LENGTH = 2'd2
  } cfg_index_t;

  localparam logic [MODEL_W-1:0] MODEL_REV   = 2'd0;
  localparam logic [MODEL_W-1:0] MODEL_TRANS = 2'd1;
  localparam logic [MODEL_W-1:0] MODEL_BOTH  = 2'd2;

  localparam logic               SIGNED_RESET = 1'b0;
  localparam logic [MODEL_W-1:0] MODEL_RESET  = MODEL_BOTH;
  localparam logic [LEN_W-1:0]   LEN_RESET    = 9'd256;

  typedef struct packed {
    logic               signed_mode;
    logic [MODEL_W-1:0] model;
    logic [LEN_W-1:0]   length;
  } cfg_t;

endpackage

// ===== design/spr_if.sv =====
`timescale 1ns / 1ps
interface spr_req_if;
  logic                               valid;
  logic                               ready;
  logic [spr_pkg::ACT_W-1:0]          action;
  logic [spr_pkg::POS_W-1:0]          pos_i;
  logic [spr_pkg::POS_W-1:0]          pos_j;
  logic [spr_pkg::POSK_W-1:0]         pos_k;
  logic signed [spr_pkg::ENTRY_W-1:0] value;

  modport source (output valid, action, pos_i, pos_j, pos_k, value, input ready);
  modport sink   (input valid, action, pos_i, pos_j, pos_k, value, output ready);
endinterface

interface spr_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [spr_pkg::ENTRY_W-1:0] read_value;
  logic [spr_pkg::POS_W-1:0]          position;
  logic                               found;
  logic                               flag;
  logic [spr_pkg::STAT_W-1:0]         status;

  modport source (output valid, read_value, position, found, flag, status, input ready);
  modport sink   (input valid, read_value, position, found, flag, status, output ready);
endinterface

interface spr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [spr_pkg::CFG_IDX_W-1:0]     index;
  logic [spr_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/spr_store.sv =====
`timescale 1ns / 1ps
module spr_store #(
  parameter int DEPTH = spr_pkg::MAX_ENTRIES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [spr_pkg::ENTRY_W-1:0] wdata,
  input  logic                        rea,
  input  logic [AW-1:0]               raddr_a,
  output logic [spr_pkg::ENTRY_W-1:0] qa,
  input  logic                        reb,
  input  logic [AW-1:0]               raddr_b,
  output logic [spr_pkg::ENTRY_W-1:0] qb
);

  logic [spr_pkg::ENTRY_W-1:0] mem_r [DEPTH];
  logic [spr_pkg::ENTRY_W-1:0] qa_r;
  logic [spr_pkg::ENTRY_W-1:0] qb_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read data holds while the port is not enabled
  always_ff @(posedge clk) begin
    if (rea) begin
      qa_r <= mem_r[raddr_a];
    end
    if (reb) begin
      qb_r <= mem_r[raddr_b];
    end
  end

  assign qa = qa_r;
  assign qb = qb_r;

endmodule

// ===== design/spr_seq.sv =====
`timescale 1ns / 1ps
module spr_seq #(
  parameter int MAX_ENTRIES = spr_pkg::MAX_ENTRIES_DEF,
  localparam int AW = $clog2(MAX_ENTRIES)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  spr_req_if.sink                     in_req,
  spr_rsp_if.source                   out_rsp,
  input  spr_pkg::cfg_t               cfg,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [spr_pkg::ENTRY_W-1:0] mem_wdata,
  output logic                        mem_rea,
  output logic [AW-1:0]               mem_raddr_a,
  input  logic [spr_pkg::ENTRY_W-1:0] mem_qa,
  output logic                        mem_reb,
  output logic [AW-1:0]               mem_raddr_b,
  input  logic [spr_pkg::ENTRY_W-1:0] mem_qb
);

  // counters hold positions up to the length register and one beyond
  localparam int CW = (AW + 1 > spr_pkg::LEN_W + 1) ? AW + 1 : spr_pkg::LEN_W + 1;
  localparam int EW = spr_pkg::ENTRY_W;
  localparam int PW = spr_pkg::POS_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DISP = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_WA   = 8'b0000_1000,
    S_WB   = 8'b0001_0000,
    S_SCAN = 8'b0010_0000,
    S_PAIR = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  function automatic logic [EW:0] mag_of(logic [EW-1:0] e);
    logic [EW:0] s;
    s = {e[EW-1], e};
    return s[EW] ? (~s + 1'b1) : s;
  endfunction

  function automatic logic [EW-1:0] neg_of(logic [EW-1:0] e);
    return ~e + 1'b1;
  endfunction

  // breakpoint between x and its successor y
  function automatic logic brk_of(logic [EW-1:0] ex, logic [EW-1:0] ey, logic use_abs);
    logic [EW:0] d;
    d = {ey[EW-1], ey} - {ex[EW-1], ex};
    return use_abs ? ((d != (EW+1)'(1)) && (d != {(EW+1){1'b1}})) : (d != (EW+1)'(1));
  endfunction

  state_t               state_r, state_nxt;
  spr_pkg::action_t     act_r, act_nxt;
  logic [PW-1:0]        pi_r, pi_nxt;
  logic [PW-1:0]        pj_r, pj_nxt;
  logic [spr_pkg::POSK_W-1:0] pk_r, pk_nxt;
  logic [EW-1:0]        val_r, val_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic                 neg_r, neg_nxt;
  logic [1:0]           pass_r, pass_nxt;
  logic [CW-1:0]        iss_r, iss_nxt;
  logic                 pv_r, pv_nxt;
  logic [CW-1:0]        pa_r, pa_nxt;
  logic [EW-1:0]        prev_r, prev_nxt;
  logic [EW-1:0]        res_rd_r, res_rd_nxt;
  logic [PW-1:0]        res_pos_r, res_pos_nxt;
  logic                 res_found_r, res_found_nxt;
  logic                 res_flag_r, res_flag_nxt;
  spr_pkg::status_t     res_status_r, res_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [EW-1:0]        out_rd_r, out_rd_nxt;
  logic [PW-1:0]        out_pos_r, out_pos_nxt;
  logic                 out_found_r, out_found_nxt;
  logic                 out_flag_r, out_flag_nxt;
  spr_pkg::status_t     out_status_r, out_status_nxt;

  logic [CW-1:0] len_x, max_x, n_w, n_m1;
  logic [CW-1:0] pi_x, pj_x, pk_x;
  logic [CW-1:0] lp1, hm1, pa_m1;
  logic          use_abs, rev_ok, trn_ok;

  assign len_x = CW'(cfg.length);
  assign max_x = CW'(MAX_ENTRIES);
  assign n_w   = (len_x > max_x) ? max_x : len_x;
  assign n_m1  = n_w - 1'b1;
  assign pi_x  = CW'(pi_r);
  assign pj_x  = CW'(pj_r);
  assign pk_x  = CW'(pk_r);
  assign lp1   = lo_r + 1'b1;
  assign hm1   = hi_r - 1'b1;
  assign pa_m1 = pa_r - 1'b1;

  assign rev_ok  = (cfg.model == spr_pkg::MODEL_REV)   || (cfg.model == spr_pkg::MODEL_BOTH);
  assign trn_ok  = (cfg.model == spr_pkg::MODEL_TRANS) || (cfg.model == spr_pkg::MODEL_BOTH);
  assign use_abs = rev_ok && !cfg.signed_mode;

  assign in_req.ready       = (state_r == S_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.read_value = out_rd_r;
  assign out_rsp.position   = out_pos_r;
  assign out_rsp.found      = out_found_r;
  assign out_rsp.flag       = out_flag_r;
  assign out_rsp.status     = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    pi_nxt         = pi_r;
    pj_nxt         = pj_r;
    pk_nxt         = pk_r;
    val_nxt        = val_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    neg_nxt        = neg_r;
    pass_nxt       = pass_r;
    iss_nxt        = iss_r;
    pv_nxt         = pv_r;
    pa_nxt         = pa_r;
    prev_nxt       = prev_r;
    res_rd_nxt     = res_rd_r;
    res_pos_nxt    = res_pos_r;
    res_found_nxt  = res_found_r;
    res_flag_nxt   = res_flag_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_rd_nxt     = out_rd_r;
    out_pos_nxt    = out_pos_r;
    out_found_nxt  = out_found_r;
    out_flag_nxt   = out_flag_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_rea        = 1'b0;
    mem_raddr_a    = '0;
    mem_reb        = 1'b0;
    mem_raddr_b    = '0;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          act_nxt   = spr_pkg::action_t'(in_req.action);
          pi_nxt    = in_req.pos_i;
          pj_nxt    = in_req.pos_j;
          pk_nxt    = in_req.pos_k;
          val_nxt   = in_req.value;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        res_rd_nxt     = '0;
        res_pos_nxt    = '0;
        res_found_nxt  = 1'b0;
        res_flag_nxt   = 1'b0;
        res_status_nxt = spr_pkg::ST_OK;
        pv_nxt         = 1'b0;
        state_nxt      = S_FIN;
        case (act_r)
          spr_pkg::ACT_WRITE: begin
            if (pi_x >= n_w) begin
              res_status_nxt = spr_pkg::ST_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = pi_x[AW-1:0];
              mem_wdata = val_r;
            end
          end
          spr_pkg::ACT_READ: begin
            if (pi_x >= n_w) begin
              res_status_nxt = spr_pkg::ST_RANGE;
            end else begin
              mem_rea     = 1'b1;
              mem_raddr_a = pi_x[AW-1:0];
              state_nxt   = S_PAIR;
            end
          end
          spr_pkg::ACT_REVERSE: begin
            if (!rev_ok) begin
              res_status_nxt = spr_pkg::ST_NOT_ALLOWED;
            end else if (pi_x >= n_w || pj_x >= n_w) begin
              res_status_nxt = spr_pkg::ST_RANGE;
            end else if (pi_x <= pj_x) begin
              lo_nxt    = pi_x;
              hi_nxt    = pj_x + 1'b1;
              neg_nxt   = cfg.signed_mode;
              pass_nxt  = 2'd0;
              state_nxt = S_RD;
            end
          end
          spr_pkg::ACT_TRANSPOSE: begin
            if (!trn_ok) begin
              res_status_nxt = spr_pkg::ST_NOT_ALLOWED;
            end else if (!(pi_x <= pj_x && pj_x <= pk_x && pk_x <= n_w)) begin
              res_status_nxt = spr_pkg::ST_RANGE;
            end else begin
              // block swap as three reversals: first block, second block, whole span
              lo_nxt    = pi_x;
              hi_nxt    = pj_x;
              neg_nxt   = 1'b0;
              pass_nxt  = 2'd2;
              state_nxt = S_RD;
            end
          end
          spr_pkg::ACT_FIND: begin
            iss_nxt   = '0;
            state_nxt = S_SCAN;
          end
          spr_pkg::ACT_BREAK: begin
            if (pi_x >= n_w || pj_x >= n_w) begin
              res_status_nxt = spr_pkg::ST_RANGE;
            end else begin
              mem_rea     = 1'b1;
              mem_raddr_a = pi_x[AW-1:0];
              mem_reb     = 1'b1;
              mem_raddr_b = pj_x[AW-1:0];
              state_nxt   = S_PAIR;
            end
          end
          spr_pkg::ACT_STRIP: begin
            if (pi_x >= n_w) begin
              res_status_nxt = spr_pkg::ST_RANGE;
            end else begin
              iss_nxt   = pi_x;
              state_nxt = S_SCAN;
            end
          end
          spr_pkg::ACT_SORTED: begin
            res_flag_nxt = 1'b1;
            iss_nxt      = '0;
            state_nxt    = S_SCAN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      S_RD: begin
        if (lp1 < hi_r) begin
          mem_rea     = 1'b1;
          mem_raddr_a = lo_r[AW-1:0];
          mem_reb     = 1'b1;
          mem_raddr_b = hm1[AW-1:0];
          state_nxt   = S_WA;
        end else if (lp1 == hi_r && neg_r) begin
          // odd span: the middle entry only changes sign
          mem_rea     = 1'b1;
          mem_raddr_a = lo_r[AW-1:0];
          state_nxt   = S_WA;
        end else if (pass_r == 2'd2) begin
          lo_nxt   = pj_x;
          hi_nxt   = pk_x;
          pass_nxt = 2'd1;
        end else if (pass_r == 2'd1) begin
          lo_nxt   = pi_x;
          hi_nxt   = pk_x;
          pass_nxt = 2'd0;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_WA: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r[AW-1:0];
        if (lp1 == hi_r) begin
          mem_wdata = neg_of(mem_qa);
          lo_nxt    = hi_r;
          state_nxt = S_RD;
        end else begin
          mem_wdata = neg_r ? neg_of(mem_qb) : mem_qb;
          state_nxt = S_WB;
        end
      end

      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = hm1[AW-1:0];
        mem_wdata = neg_r ? neg_of(mem_qa) : mem_qa;
        lo_nxt    = lp1;
        hi_nxt    = hm1;
        state_nxt = S_RD;
      end

      S_PAIR: begin
        if (act_r == spr_pkg::ACT_READ) begin
          res_rd_nxt = mem_qa;
        end else begin
          res_flag_nxt = brk_of(mem_qa, mem_qb, use_abs);
        end
        state_nxt = S_FIN;
      end

      S_SCAN: begin
        // one read issued per cycle, its data handled in the next cycle
        if (iss_r < n_w) begin
          mem_rea     = 1'b1;
          mem_raddr_a = iss_r[AW-1:0];
          iss_nxt     = iss_r + 1'b1;
          pv_nxt      = 1'b1;
          pa_nxt      = iss_r;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          prev_nxt = mem_qa;
          case (act_r)
            spr_pkg::ACT_FIND: begin
              if (mag_of(mem_qa) == mag_of(val_r)) begin
                res_pos_nxt   = pa_r[PW-1:0];
                res_found_nxt = (mem_qa == val_r);
              end
            end
            spr_pkg::ACT_SORTED: begin
              if (pa_r != '0 && $signed(prev_r) > $signed(mem_qa)) begin
                res_flag_nxt = 1'b0;
                state_nxt    = S_FIN;
              end
            end
            spr_pkg::ACT_STRIP: begin
              if (pa_r != pi_x && brk_of(prev_r, mem_qa, use_abs)) begin
                res_pos_nxt = pa_m1[PW-1:0];
                state_nxt   = S_FIN;
              end
            end
            default: begin
              prev_nxt = mem_qa;
            end
          endcase
        end
        if (!pv_r && iss_r >= n_w) begin
          state_nxt = S_FIN;
          if (act_r == spr_pkg::ACT_FIND && !res_found_r) begin
            res_pos_nxt = '0;
          end
          if (act_r == spr_pkg::ACT_STRIP) begin
            res_pos_nxt = n_m1[PW-1:0];
          end
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_rd_nxt     = res_rd_r;
          out_pos_nxt    = res_pos_r;
          out_found_nxt  = res_found_r;
          out_flag_nxt   = res_flag_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    pi_r         <= pi_nxt;
    pj_r         <= pj_nxt;
    pk_r         <= pk_nxt;
    val_r        <= val_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    neg_r        <= neg_nxt;
    pass_r       <= pass_nxt;
    iss_r        <= iss_nxt;
    pv_r         <= pv_nxt;
    pa_r         <= pa_nxt;
    prev_r       <= prev_nxt;
    res_rd_r     <= res_rd_nxt;
    res_pos_r    <= res_pos_nxt;
    res_found_r  <= res_found_nxt;
    res_flag_r   <= res_flag_nxt;
    res_status_r <= res_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_pos_r    <= out_pos_nxt;
    out_found_r  <= out_found_nxt;
    out_flag_r   <= out_flag_nxt;
    out_status_r <= out_status_nxt;
  end

  // reads and writes never share a cycle, so no bypass path is needed
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && (mem_rea || mem_reb)))
    else $error("store read and write in the same cycle");

  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WA || state_r == S_WB) |-> (lo_r < hi_r))
    else $error("swap pointers crossed");

  a_wb_after_wa: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> ($past(state_r) == S_WA))
    else $error("second swap write without first");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result presented outside finish");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_PAIR) |-> !mem_we)
    else $error("store written during a search");

endmodule

// ===== design/signed_permutation_rearranger.sv =====
`timescale 1ns / 1ps
// channel   | dir | handshake    | payload
// in_req    | in  | valid/ready  | action, pos_i, pos_j, pos_k, value
// out_rsp   | out | valid/ready  | read_value, position, found, flag, status
// cfg_wr    | in  | valid/ready  | index, data (ready always high)
//
// one request at a time; find scans every entry, sorted check stops at the first descent,
// strip end scans from pos_i to the first breakpoint; reverse reads each swapped pair and
// writes it back one entry at a time (a negated middle entry is rewritten alone), transpose
// runs as three reversals; the store's single write port sets the swap rate
// reset is synchronous and clears control only; the entry store is not cleared
// a finished result sits in the output register while the next request is taken
module signed_permutation_rearranger #(
  parameter int MAX_ENTRIES = spr_pkg::MAX_ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  spr_req_if.sink   in_req,
  spr_rsp_if.source out_rsp,
  spr_cfg_if.sink   cfg_wr
);

  localparam int AW = $clog2(MAX_ENTRIES);

  logic                              sgn_r, sgn_nxt;
  logic [spr_pkg::MODEL_W-1:0]       model_r, model_nxt;
  logic [spr_pkg::LEN_W-1:0]         len_r, len_nxt;
  spr_pkg::cfg_t                     cfg;

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic [spr_pkg::ENTRY_W-1:0]       mem_wdata;
  logic                              mem_rea;
  logic [AW-1:0]                     mem_raddr_a;
  logic [spr_pkg::ENTRY_W-1:0]       mem_qa;
  logic                              mem_reb;
  logic [AW-1:0]                     mem_raddr_b;
  logic [spr_pkg::ENTRY_W-1:0]       mem_qb;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    sgn_nxt   = sgn_r;
    model_nxt = model_r;
    len_nxt   = len_r;
    if (cfg_wr.valid) begin
      case (spr_pkg::cfg_index_t'(cfg_wr.index))
        spr_pkg::CFG_SIGNED: begin
          sgn_nxt = cfg_wr.data[0];
        end
        spr_pkg::CFG_MODEL: begin
          model_nxt = cfg_wr.data[spr_pkg::MODEL_W-1:0];
        end
        spr_pkg::CFG_LENGTH: begin
          len_nxt = cfg_wr.data[spr_pkg::LEN_W-1:0];
        end
        default: begin
          sgn_nxt = sgn_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sgn_r   <= spr_pkg::SIGNED_RESET;
      model_r <= spr_pkg::MODEL_RESET;
      len_r   <= spr_pkg::LEN_RESET;
    end else begin
      sgn_r   <= sgn_nxt;
      model_r <= model_nxt;
      len_r   <= len_nxt;
    end
  end

  assign cfg.signed_mode = sgn_r;
  assign cfg.model       = model_r;
  assign cfg.length      = len_r;

  spr_store #(
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .rea     (mem_rea),
    .raddr_a (mem_raddr_a),
    .qa      (mem_qa),
    .reb     (mem_reb),
    .raddr_b (mem_raddr_b),
    .qb      (mem_qb)
  );

  spr_seq #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .out_rsp     (out_rsp),
    .cfg         (cfg),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_rea     (mem_rea),
    .mem_raddr_a (mem_raddr_a),
    .mem_qa      (mem_qa),
    .mem_reb     (mem_reb),
    .mem_raddr_b (mem_raddr_b),
    .mem_qb      (mem_qb)
  );

endmodule

// ===== tb/sv/perm_result_checker.sv =====
`timescale 1ns / 1ps
module perm_result_checker (
  input  logic clk,
  input  logic rst_n,
  spr_req_if   req,
  spr_rsp_if   rsp,
  spr_cfg_if   cfg,
  output int   mismatches,
  output int   awaited
);
  import spr_pkg::*;

  typedef struct {
    logic signed [ENTRY_W-1:0] read_value;
    logic [POS_W-1:0]          position;
    logic                      found;
    logic                      flag;
    status_t                   status;
  } outcome_t;

  logic signed [ENTRY_W-1:0] perm    [MAX_ENTRIES_DEF];
  logic signed [ENTRY_W-1:0] staging [MAX_ENTRIES_DEF];
  logic                      signed_mode;
  logic [MODEL_W-1:0]        model;
  logic [LEN_W-1:0]          length;
  outcome_t                  pending_outcomes[$];

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic breaks_between(int x, int y);
    int d;
    d = int'(perm[y]) - int'(perm[x]);
    // unsigned reversal models compare adjacency in either direction
    if ((model == MODEL_REV || model == MODEL_BOTH) && !signed_mode)
      return magnitude(d) != 1;
    return d != 1;
  endfunction

  function automatic outcome_t apply_action(action_t act, int pi, int pj, int pk,
                                            logic signed [ENTRY_W-1:0] val);
    outcome_t                  o;
    int                        n, a, b, w, idx;
    logic                      hit;
    logic signed [ENTRY_W-1:0] t;
    o.read_value = '0;
    o.position   = '0;
    o.found      = 1'b0;
    o.flag       = 1'b0;
    o.status     = ST_OK;
    n = (int'(length) > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(length);
    case (act)
      ACT_WRITE: begin
        if (pi >= n) o.status = ST_RANGE;
        else perm[pi] = val;
      end
      ACT_READ: begin
        if (pi >= n) o.status = ST_RANGE;
        else o.read_value = perm[pi];
      end
      ACT_REVERSE: begin
        if (model != MODEL_REV && model != MODEL_BOTH) o.status = ST_NOT_ALLOWED;
        else if (pi >= n || pj >= n) o.status = ST_RANGE;
        else if (pi <= pj) begin
          a = pi;
          b = pj;
          while (a < b) begin
            t       = perm[a];
            perm[a] = perm[b];
            perm[b] = t;
            a++;
            b--;
          end
          // negating the most negative entry wraps back onto itself
          if (signed_mode)
            for (a = pi; a <= pj; a++) perm[a] = -perm[a];
        end
      end
      ACT_TRANSPOSE: begin
        if (model != MODEL_TRANS && model != MODEL_BOTH) o.status = ST_NOT_ALLOWED;
        else if (!(pi <= pj && pj <= pk && pk <= n)) o.status = ST_RANGE;
        else begin
          w = 0;
          for (a = pj; a < pk; a++) begin
            staging[w] = perm[a];
            w++;
          end
          for (a = pi; a < pj; a++) begin
            staging[w] = perm[a];
            w++;
          end
          for (a = 0; a < w; a++) perm[pi + a] = staging[a];
        end
      end
      ACT_FIND: begin
        hit = 1'b0;
        idx = 0;
        // last position with a matching magnitude wins, then the sign decides
        for (a = 0; a < n; a++)
          if (magnitude(int'(perm[a])) == magnitude(int'(val))) begin
            hit = 1'b1;
            idx = a;
          end
        if (hit && perm[idx] == val) begin
          o.found    = 1'b1;
          o.position = POS_W'(idx);
        end
      end
      ACT_BREAK: begin
        if (pi >= n || pj >= n) o.status = ST_RANGE;
        else o.flag = breaks_between(pi, pj);
      end
      ACT_STRIP: begin
        if (pi >= n) o.status = ST_RANGE;
        else begin
          a = pi;
          while (a + 1 < n && !breaks_between(a, a + 1)) a++;
          o.position = POS_W'(a);
        end
      end
      ACT_SORTED: begin
        o.flag = 1'b1;
        for (a = 1; a < n; a++)
          if (perm[a - 1] > perm[a]) begin
            o.flag = 1'b0;
            break;
          end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic check_field(string field, logic signed [31:0] expected,
                             logic signed [31:0] actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected %0d, got %0d", field, expected, actual);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      signed_mode = SIGNED_RESET;
      model       = MODEL_RESET;
      length      = LEN_RESET;
      mismatches  = 0;
      pending_outcomes.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_SIGNED: signed_mode = cfg.data[0];
          CFG_MODEL:  model       = cfg.data[MODEL_W-1:0];
          CFG_LENGTH: length      = cfg.data[LEN_W-1:0];
          default: ;
        endcase
      end
      // retire before predicting so a stray response never takes a fresh entry
      if (rsp.valid && rsp.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("response with no request waiting");
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("position", {24'd0, want.position}, {24'd0, rsp.position});
          check_field("found", {31'd0, want.found}, {31'd0, rsp.found});
          check_field("flag", {31'd0, want.flag}, {31'd0, rsp.flag});
          check_field("status", {30'd0, want.status}, {30'd0, rsp.status});
        end
      end
      if (req.valid && req.ready)
        pending_outcomes.insert(pending_outcomes.size(),
                                apply_action(action_t'(req.action), req.pos_i,
                                             req.pos_j, req.pos_k, req.value));
    end
    awaited <= pending_outcomes.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import spr_pkg::*;

  localparam logic [MODEL_W-1:0] MODEL_NONE = 2'd3;

  typedef struct {
    action_t                   act;
    logic [POS_W-1:0]          pi;
    logic [POS_W-1:0]          pj;
    logic [POSK_W-1:0]         pk;
    logic signed [ENTRY_W-1:0] val;
  } request_t;

  logic clk;
  logic rst_n;
  logic quiet;
  int   hold_asks;
  int   mismatches;
  int   awaited;
  int   requests_sent;
  int   settings_run;

  spr_req_if req_ch ();
  spr_rsp_if rsp_ch ();
  spr_cfg_if cfg_ch ();

  signed_permutation_rearranger i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  perm_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // response side: short random back-pressure, plus one long hold when asked
  initial begin
    int burst;
    int hold;
    int seen;
    burst = 0;
    hold  = 0;
    seen  = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != seen) begin
        seen = hold_asks;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else if (quiet) begin
        rsp_ch.ready <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        burst = $urandom_range(0, 7);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic request_t make_req(action_t a, int pi, int pj, int pk, int val);
    request_t r;
    r.act = a;
    r.pi  = POS_W'(pi);
    r.pj  = POS_W'(pj);
    r.pk  = POSK_W'(pk);
    r.val = ENTRY_W'(val);
    return r;
  endfunction

  function automatic int pick_pos(int n);
    if (n == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, n - 1);
  endfunction

  function automatic int pick_value(int n);
    int m;
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 511)) - 256;
    m = $urandom_range(0, (n > 1) ? n - 1 : 1);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic request_t random_request(int n);
    request_t r;
    int       sel, lo, mid, hi, t;
    r   = make_req(ACT_READ, pick_pos(n), pick_pos(n), $urandom_range(0, 511),
                   pick_value(n));
    sel = $urandom_range(0, 99);
    if (sel < 8) r.act = ACT_WRITE;
    else if (sel < 18) r.act = ACT_READ;
    else if (sel < 38) r.act = ACT_REVERSE;
    else if (sel < 58) begin
      r.act = ACT_TRANSPOSE;
      // mostly well-formed block bounds, the rest left as noise
      if ($urandom_range(0, 9) != 0) begin
        lo  = $urandom_range(0, n);
        mid = $urandom_range(0, n);
        hi  = $urandom_range(0, n);
        if (lo > mid) begin t = lo; lo = mid; mid = t; end
        if (mid > hi) begin t = mid; mid = hi; hi = t; end
        if (lo > mid) begin t = lo; lo = mid; mid = t; end
        r.pi = POS_W'(lo);
        r.pj = POS_W'(mid);
        r.pk = POSK_W'(hi);
      end
    end
    else if (sel < 70) r.act = ACT_FIND;
    else if (sel < 80) begin
      r.act = ACT_BREAK;
      if ($urandom_range(0, 1) == 1) r.pj = r.pi + 1'b1;
    end
    else if (sel < 90) r.act = ACT_STRIP;
    else r.act = ACT_SORTED;
    return r;
  endfunction

  // valid stays high from one request to the next unless a gap is taken
  task automatic send_request(request_t r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= r.act;
    req_ch.pos_i  <= r.pi;
    req_ch.pos_j  <= r.pj;
    req_ch.pos_k  <= r.pk;
    req_ch.value  <= r.val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  task automatic write_register(cfg_index_t idx, int d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(d);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic sgn, logic [MODEL_W-1:0] mdl, int len);
    wait_drained();
    write_register(CFG_SIGNED, sgn);
    write_register(CFG_MODEL, mdl);
    write_register(CFG_LENGTH, len);
    settings_run++;
  endtask

  // sentinels at both ends, shuffled interior, random signs in signed mode
  task automatic load_permutation(logic sgn, int n);
    int order[MAX_ENTRIES_DEF];
    int k, s, t;
    for (k = 0; k < n; k++) order[k] = k;
    for (k = n - 2; k > 1; k--) begin
      s        = $urandom_range(1, k);
      t        = order[k];
      order[k] = order[s];
      order[s] = t;
    end
    for (k = 0; k < n; k++) begin
      if (sgn && k > 0 && k < n - 1 && $urandom_range(0, 1) == 1) order[k] = -order[k];
      send_request(make_req(ACT_WRITE, k, $urandom_range(0, 255), $urandom_range(0, 511),
                            order[k]));
    end
  endtask

  task automatic run_random(logic sgn, logic [MODEL_W-1:0] mdl, int len, int count,
                            bit long_hold);
    int n, k;
    apply_setting(sgn, mdl, len);
    n = (len > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : len;
    if (n >= 3) load_permutation(sgn, n);
    for (k = 0; k < count; k++) begin
      if (long_hold && k == count / 4) hold_asks <= hold_asks + 1;
      send_request(random_request(n));
    end
  endtask

  initial begin
    int k;
    requests_sent = 0;
    settings_run  = 0;
    rst_n         <= 1'b0;
    quiet         <= 1'b0;
    hold_asks     <= 0;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_WRITE;
    req_ch.pos_i  <= '0;
    req_ch.pos_j  <= '0;
    req_ch.pos_k  <= '0;
    req_ch.value  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_SIGNED;
    cfg_ch.data   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every entry gets written once under the reset length before anything reads
    for (k = 0; k < MAX_ENTRIES_DEF; k++) send_request(make_req(ACT_WRITE, k, 0, 0, k));

    apply_setting(1'b1, MODEL_BOTH, 8);
    send_request(make_req(ACT_WRITE, 1, 0, 0, -256));
    send_request(make_req(ACT_REVERSE, 1, 3, 0, 0));
    send_request(make_req(ACT_READ, 3, 0, 0, 0));
    send_request(make_req(ACT_REVERSE, 5, 2, 0, 0));
    send_request(make_req(ACT_REVERSE, 4, 4, 0, 0));
    send_request(make_req(ACT_REVERSE, 0, 255, 0, 0));
    send_request(make_req(ACT_TRANSPOSE, 1, 3, 6, 0));
    send_request(make_req(ACT_TRANSPOSE, 2, 2, 2, 0));
    send_request(make_req(ACT_TRANSPOSE, 0, 3, 8, 0));
    send_request(make_req(ACT_TRANSPOSE, 3, 2, 5, 0));
    send_request(make_req(ACT_TRANSPOSE, 0, 4, 511, 0));
    send_request(make_req(ACT_FIND, 0, 0, 0, -256));
    send_request(make_req(ACT_FIND, 0, 0, 0, 5));
    send_request(make_req(ACT_FIND, 0, 0, 0, -5));
    send_request(make_req(ACT_FIND, 0, 0, 0, 255));
    send_request(make_req(ACT_BREAK, 0, 7, 0, 0));
    send_request(make_req(ACT_BREAK, 255, 0, 0, 0));
    send_request(make_req(ACT_STRIP, 0, 0, 0, 0));
    send_request(make_req(ACT_STRIP, 255, 0, 0, 0));
    send_request(make_req(ACT_SORTED, 0, 0, 0, 0));
    send_request(make_req(ACT_READ, 255, 0, 0, 0));
    send_request(make_req(ACT_WRITE, 8, 0, 0, 1));
    apply_setting(1'b0, MODEL_REV, 8);
    send_request(make_req(ACT_TRANSPOSE, 0, 1, 2, 0));
    send_request(make_req(ACT_BREAK, 7, 6, 0, 0));
    apply_setting(1'b1, MODEL_TRANS, 8);
    send_request(make_req(ACT_REVERSE, 255, 255, 0, 0));
    apply_setting(1'b0, MODEL_NONE, 1);
    send_request(make_req(ACT_REVERSE, 0, 0, 0, 0));
    send_request(make_req(ACT_TRANSPOSE, 0, 0, 1, 0));
    send_request(make_req(ACT_SORTED, 0, 0, 0, 0));

    run_random(1'b0, MODEL_BOTH, 16, 150, 1'b0);
    run_random(1'b1, MODEL_BOTH, 16, 150, 1'b1);
    run_random(1'b1, MODEL_REV, 12, 70, 1'b0);
    run_random(1'b0, MODEL_REV, 24, 70, 1'b0);
    run_random(1'b0, MODEL_TRANS, 10, 70, 1'b0);
    run_random(1'b1, MODEL_TRANS, 32, 70, 1'b0);
    run_random(1'b1, MODEL_NONE, 8, 40, 1'b0);
    run_random(1'b1, MODEL_BOTH, 256, 40, 1'b0);
    run_random(1'b0, MODEL_BOTH, 511, 30, 1'b0);
    run_random(1'b1, MODEL_BOTH, 2, 40, 1'b0);
    run_random(1'b0, MODEL_BOTH, 1, 20, 1'b0);
    run_random(1'b1, MODEL_BOTH, 0, 20, 1'b0);

    // closing stretch runs flat out on both sides
    wait_drained();
    quiet <= 1'b1;
    run_random(1'b1, MODEL_BOTH, 20, 200, 1'b0);

    wait_drained();
    repeat (800) @(posedge clk);
    $display("run covered %0d requests under %0d register settings", requests_sent,
             settings_run);
    $display("lengths 0 to 511, all model codes, both sign modes, long output stall");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("timeout: block stopped answering requests");
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/spr_pkg.sv
design/spr_if.sv
design/spr_store.sv
design/spr_seq.sv
design/signed_permutation_rearranger.sv
tb/sv/perm_result_checker.sv
tb/sv/tb.sv
